@@ src/stt_pkg.sv @@
`default_nettype none
package stt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_EXPIRED     = 16;
  localparam int EXP_CNT_W       = $clog2(MAX_EXPIRED + 1);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_DELETE  = 2'd2,
    OP_DEL_ALL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    EV_DONE    = 2'd0,
    EV_EXPIRED = 2'd1,
    EV_FULL    = 2'd2,
    EV_UNUSED  = 2'd3
  } event_kind_t;

  // 48-bit add of a 32-bit amount that sticks at the top value.
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

endpackage
`default_nettype wire

@@ src/software_timer_table.sv @@
// Channel | Direction | Data                                      | Side band
// s_*     | in        | tdata: timer_id, start_delay, expire_delay, | tuser: opcode
//         |           |        reload_period, user_tag            |
// m_*     | out       | tdata: expired_id, expired_tag           | tuser: event_kind,
//         |           |                                           | tlast: last_event
// Add and delete walk the slot memories once, one slot per cycle, then hand over their
// result; delete-all hands over its result without a walk. A tick walks once per
// expired timer, plus once more unless the sixteenth expiry ends it.
// Reset clears the time count and all slot valid bits; no clearing pass is needed.
// The input is taken only while no transaction is in progress; a stalled output holds
// the walk at the point where the next result has to be handed over.
`default_nettype none
module software_timer_table
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // timer_id[15:0], start_delay[47:16], expire_delay[79:48],
  // reload_period[111:80], user_tag[143:112]
  input  wire logic [143:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // expired_id[15:0], expired_tag[47:16]
  output logic [47:0]       m_tdata,
  // event_kind[1:0]
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  localparam int SW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL, S_CMD_OUT} state_t;

  state_t state;

  logic [15:0] mem_id  [TABLE_DEPTH];
  logic [47:0] mem_dl  [TABLE_DEPTH];
  logic [31:0] mem_per [TABLE_DEPTH];
  logic [31:0] mem_tag [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] done;
  logic [47:0] now;

  logic [CW-1:0] cnt;
  logic          rd_vld;
  logic [SW-1:0] rd_slot;
  logic [15:0]   rd_id;
  logic [47:0]   rd_dl;
  logic [31:0]   rd_per;
  logic [31:0]   rd_tag;

  opcode_t     cmd_op;
  logic [15:0] cmd_id;
  logic [31:0] cmd_expire;
  logic [31:0] cmd_per;
  logic [31:0] cmd_tag;
  logic [47:0] cmd_base;
  logic [47:0] cmd_dl;
  event_kind_t cmd_kind;

  logic          mfound;
  logic [SW-1:0] mslot;
  logic          ffound;
  logic [SW-1:0] fslot;

  logic          found;
  logic [SW-1:0] best_slot;
  logic [15:0]   best_id;
  logic [47:0]   best_dl;
  logic [31:0]   best_per;
  logic [31:0]   best_tag;

  logic          has_pend;
  logic [15:0]   pend_id;
  logic [31:0]   pend_tag;
  logic [EXP_CNT_W-1:0] n_exp;

  logic          scan_done;
  logic          out_free;
  logic          out_load;
  logic          tick_act;
  logic          add_act;
  logic [SW-1:0] add_slot;
  logic [47:0]   rearm_dl;

  always_comb begin
    scan_done = (state == S_SCAN) && (cnt == CW'(TABLE_DEPTH)) && !rd_vld;
    out_free  = !m_tvalid || m_tready;
    tick_act  = scan_done && (cmd_op == OP_TICK) && found && (!has_pend || out_free);
    out_load  = (tick_act && has_pend) ||
                ((state == S_FINAL || state == S_CMD_OUT) && out_free);
    add_act   = scan_done && (cmd_op == OP_ADD) && (mfound || ffound);
    add_slot  = mfound ? mslot : fslot;
    rearm_dl  = sat_add48(best_dl, best_per);
    s_tready  = (state == S_IDLE);
  end

  // Slot memories: one read port for the walk, one write port.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && cnt < CW'(TABLE_DEPTH)) begin
      rd_id  <= mem_id[cnt[SW-1:0]];
      rd_dl  <= mem_dl[cnt[SW-1:0]];
      rd_per <= mem_per[cnt[SW-1:0]];
      rd_tag <= mem_tag[cnt[SW-1:0]];
    end
    if (add_act) begin
      mem_id[add_slot]  <= cmd_id;
      mem_dl[add_slot]  <= cmd_dl;
      mem_per[add_slot] <= cmd_per;
      mem_tag[add_slot] <= cmd_tag;
    end else if (tick_act && best_per != 32'd0) begin
      mem_dl[best_slot] <= rearm_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      now      <= '0;
      rd_vld   <= 1'b0;
      has_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_op     <= opcode_t'(s_tuser);
            cmd_id     <= (opcode_t'(s_tuser) == OP_DEL_ALL) ? 16'd0 : s_tdata[15:0];
            cmd_expire <= s_tdata[79:48];
            cmd_per    <= s_tdata[111:80];
            cmd_tag    <= s_tdata[143:112];
            cmd_base   <= sat_add48(now, s_tdata[47:16]);
            cnt        <= '0;
            mfound     <= 1'b0;
            ffound     <= 1'b0;
            found      <= 1'b0;
            done       <= '0;
            n_exp      <= '0;
            has_pend   <= 1'b0;
            unique case (opcode_t'(s_tuser))
              OP_TICK: begin
                now   <= now + 48'd1;
                state <= S_SCAN;
              end
              OP_DEL_ALL: begin
                valid    <= '0;
                cmd_kind <= EV_DONE;
                state    <= S_CMD_OUT;
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmd_dl <= sat_add48(cmd_base, cmd_expire);
          if (cnt < CW'(TABLE_DEPTH)) begin
            rd_slot <= cnt[SW-1:0];
            rd_vld  <= 1'b1;
            cnt     <= cnt + CW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (cmd_op == OP_TICK) begin
              // Ascending walk with a strict compare keeps the lower slot on ties.
              if (valid[rd_slot] && !done[rd_slot] && rd_dl <= now &&
                  (!found || rd_dl < best_dl)) begin
                found     <= 1'b1;
                best_slot <= rd_slot;
                best_id   <= rd_id;
                best_dl   <= rd_dl;
                best_per  <= rd_per;
                best_tag  <= rd_tag;
              end
            end else begin
              if (valid[rd_slot] && rd_id == cmd_id && !mfound) begin
                mfound <= 1'b1;
                mslot  <= rd_slot;
              end
              if (!valid[rd_slot] && !ffound) begin
                ffound <= 1'b1;
                fslot  <= rd_slot;
              end
            end
          end
          if (scan_done) begin
            if (cmd_op == OP_TICK) begin
              if (found) begin
                if (tick_act) begin
                  if (best_per == 32'd0) begin
                    valid[best_slot] <= 1'b0;
                  end
                  done[best_slot] <= 1'b1;
                  if (has_pend) begin
                    m_tvalid <= 1'b1;
                    m_tdata  <= {pend_tag, pend_id};
                    m_tuser  <= EV_EXPIRED;
                    m_tlast  <= 1'b0;
                  end
                  has_pend <= 1'b1;
                  pend_id  <= best_id;
                  pend_tag <= best_tag;
                  n_exp    <= n_exp + EXP_CNT_W'(1);
                  found    <= 1'b0;
                  cnt      <= '0;
                  if (n_exp + EXP_CNT_W'(1) == EXP_CNT_W'(MAX_EXPIRED)) begin
                    state <= S_FINAL;
                  end
                end
              end else if (has_pend) begin
                state <= S_FINAL;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              if (cmd_op == OP_ADD) begin
                if (mfound || ffound) begin
                  valid[add_slot] <= 1'b1;
                  cmd_kind        <= EV_DONE;
                end else begin
                  cmd_kind <= EV_FULL;
                end
              end else begin
                if (mfound) begin
                  valid[mslot] <= 1'b0;
                end
                cmd_kind <= EV_DONE;
              end
              state <= S_CMD_OUT;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {pend_tag, pend_id};
            m_tuser  <= EV_EXPIRED;
            m_tlast  <= 1'b1;
            has_pend <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_CMD_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {32'd0, cmd_id};
            m_tuser  <= cmd_kind;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
